// File: sv/wfct_pkg.sv
// Package of the weighted feed consensus table: default sizes, constants,
// controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wfct_pkg;

   localparam int INSTRUMENT_COUNT_DEFAULT = 16;
   localparam int SOURCE_COUNT_DEFAULT     = 8;
   localparam int PRICE_BITS_DEFAULT       = 32;

   localparam logic [17:0] WEIGHT_MAX = 18'h3FFFF;
   localparam logic [17:0] USE_HALF   = 18'd32768;
   localparam logic [16:0] CONF_ONE   = 17'd65536;

   typedef enum logic [0:0] {
      OP_INGEST = 1'b0,
      OP_QUERY  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      DIV_MID,
      DIV_SPR,
      DIV_CONF,
      DIV_DMEAN
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P1_RD,
      ST_P1_MID,
      ST_P1_MUL,
      ST_P1_ACC,
      ST_CHECK,
      ST_DIV_MID,
      ST_DIV_SPR,
      ST_DIV_CONF,
      ST_P2_CHK,
      ST_P2_RD,
      ST_P2_MID,
      ST_P2_ACC,
      ST_P2_END,
      ST_DIV_DMEAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        write_entry;
      logic        load_query;
      logic        src_clear;
      logic        src_next;
      logic        rd_issue;
      logic        p1_stage;
      logic        p1_mul;
      logic        p1_acc;
      logic        p2_stage;
      logic        p2_acc;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_capture;
      div_sel_type cap_sel;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic src_last;
      logic wsum_zero;
      logic cmid_zero;
      logic dn_zero;
      logic inst_oob;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// File: sv/wfct_div.sv
// Restoring divider of the weighted feed consensus table, one quotient bit
// per cycle. Depends on nothing; the quotient must fit in QW bits.
`timescale 1ns / 1ps
`default_nettype none
module wfct_div #(
   parameter int NW  = 62,
   parameter int DVW = 22,
   parameter int QW  = 41
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [NW-1:0]  dividend,
   input  wire logic [DVW-1:0] divisor,
   output logic                done,
   output logic [QW-1:0]       quotient
);
   localparam int CNTW = $clog2(QW + 1);

   logic [DVW-1:0]  rem_ff;
   logic [QW-1:0]   q_ff;
   logic [DVW-1:0]  d_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            done_ff;
   logic [DVW:0]    rem2;
   logic            ge;

   always_comb begin
      rem2 = {rem_ff, q_ff[QW-1]};
      ge   = (rem2 >= {1'b0, d_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNTW'(QW);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == CNTW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // The upper dividend bits are below the divisor by contract.
         rem_ff <= DVW'(dividend[NW-1:QW]);
         q_ff   <= dividend[QW-1:0];
         d_ff   <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= ge ? DVW'(rem2 - {1'b0, d_ff}) : rem2[DVW-1:0];
         q_ff   <= {q_ff[QW-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

// File: sv/wfct_datapath.sv
// Datapath of the weighted feed consensus table: quote memory, used bits,
// accumulators, multiplier, shared divider and result registers.
// Depends on wfct_pkg and wfct_div.
`timescale 1ns / 1ps
`default_nettype none
module wfct_datapath #(
   parameter int INSTRUMENT_COUNT = wfct_pkg::INSTRUMENT_COUNT_DEFAULT,
   parameter int SOURCE_COUNT     = wfct_pkg::SOURCE_COUNT_DEFAULT,
   parameter int PRICE_BITS       = wfct_pkg::PRICE_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wfct_pkg::cmd_type    cmd,
   output wfct_pkg::status_type      status,
   input  wire logic [3:0]           req_instrument_index,
   input  wire logic [2:0]           req_source_index,
   input  wire logic [31:0]          req_bid_price,
   input  wire logic [31:0]          req_ask_price,
   input  wire logic [31:0]          req_last_price,
   input  wire logic                 req_bid_present,
   input  wire logic                 req_ask_present,
   input  wire logic                 req_last_present,
   input  wire logic [16:0]          req_reliability,
   input  wire logic [16:0]          req_usefulness,
   output logic                      rsp_consensus_valid,
   output logic [39:0]               rsp_mid_price,
   output logic signed [40:0]        rsp_mean_spread,
   output logic [16:0]               rsp_confidence,
   output logic [3:0]                rsp_contributing_count,
   output logic                      rsp_divergence_valid,
   output logic [39:0]               rsp_max_divergence,
   output logic [39:0]               rsp_mean_divergence,
   output logic                      rsp_outlier_valid,
   output logic [2:0]                rsp_outlier_source
);
   localparam int ENTRIES = INSTRUMENT_COUNT * SOURCE_COUNT;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW      = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
   localparam int CW      = $clog2(SOURCE_COUNT + 1);
   localparam int PB      = PRICE_BITS;
   localparam int MIDW    = PB + 8;
   localparam int PRODW   = MIDW + 18;
   localparam int WSUMW   = PRODW + CW;
   localparam int WTSW    = 18 + CW;
   localparam int SPRW    = PB + 9;
   localparam int SPRSW   = SPRW + CW;
   localparam int DSUMW   = MIDW + CW;
   localparam int QW      = MIDW + 1;

   // Quote storage.
   logic [PB-1:0] bid_mem  [ENTRIES];
   logic [PB-1:0] ask_mem  [ENTRIES];
   logic [PB-1:0] last_mem [ENTRIES];
   logic [2:0]    pres_mem [ENTRIES];
   logic [17:0]   wt_mem   [ENTRIES];
   logic [ENTRIES-1:0] used_ff;

   logic [PB-1:0] bid_rd_ff, ask_rd_ff, last_rd_ff;
   logic [2:0]    pres_rd_ff;
   logic [17:0]   wt_rd_ff;
   logic          used_rd_ff;

   // Ingest path.
   logic          wr_ok;
   logic [31:0]   wr_full;
   logic [AW-1:0] wr_addr;
   logic [34:0]   wprod;
   logic [17:0]   wr_weight;
   logic [63:0]   bid64, ask64, last64;

   always_comb begin
      wr_ok   = (32'(req_instrument_index) < 32'(INSTRUMENT_COUNT)) &&
                (32'(req_source_index) < 32'(SOURCE_COUNT));
      wr_full = 32'(req_instrument_index) * 32'(SOURCE_COUNT) + 32'(req_source_index);
      wr_addr = wr_full[AW-1:0];
      wprod   = 35'(req_reliability) * 35'({1'b0, req_usefulness} + wfct_pkg::USE_HALF);
      wr_weight = (wprod[34:16] > 19'(wfct_pkg::WEIGHT_MAX)) ? wfct_pkg::WEIGHT_MAX
                                                             : wprod[33:16];
      bid64  = 64'(req_bid_price);
      ask64  = 64'(req_ask_price);
      last64 = 64'(req_last_price);
   end

   // Query walk state.
   logic [AW-1:0] base_ff;
   logic [SW-1:0] src_ff;
   logic [31:0]   base_full;
   logic [AW-1:0] rd_addr;

   assign base_full = 32'(req_instrument_index) * 32'(SOURCE_COUNT);
   assign rd_addr   = AW'(base_ff + AW'(src_ff));

   always_ff @(posedge clock) begin
      if (cmd.write_entry && wr_ok) begin
         bid_mem[wr_addr]  <= bid64[PB-1:0];
         ask_mem[wr_addr]  <= ask64[PB-1:0];
         last_mem[wr_addr] <= last64[PB-1:0];
         pres_mem[wr_addr] <= {req_last_present, req_ask_present, req_bid_present};
         wt_mem[wr_addr]   <= wr_weight;
      end
      if (cmd.rd_issue) begin
         bid_rd_ff  <= bid_mem[rd_addr];
         ask_rd_ff  <= ask_mem[rd_addr];
         last_rd_ff <= last_mem[rd_addr];
         pres_rd_ff <= pres_mem[rd_addr];
         wt_rd_ff   <= wt_mem[rd_addr];
         used_rd_ff <= used_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.write_entry && wr_ok) begin
         used_ff[wr_addr] <= 1'b1;
      end
   end

   // Mid and spread term of the entry just read.
   logic                   both;
   logic [MIDW-1:0]        mid_c;
   logic [PB:0]            diff_c;
   logic signed [SPRW-1:0] term_c;

   always_comb begin
      both   = (pres_rd_ff[1:0] == 2'b11);
      diff_c = {1'b0, ask_rd_ff} - {1'b0, bid_rd_ff};
      term_c = both ? $signed({diff_c, 8'd0}) : '0;
      if (both) begin
         mid_c = MIDW'({({1'b0, bid_rd_ff} + {1'b0, ask_rd_ff}), 7'd0});
      end else if (pres_rd_ff[2]) begin
         mid_c = {last_rd_ff, 8'd0};
      end else begin
         mid_c = '0;
      end
   end

   logic [MIDW-1:0]         mid_ff;
   logic [17:0]             wt_ff;
   logic                    incl_ff;
   logic signed [SPRW-1:0]  term_ff;
   logic [PRODW-1:0]        prod_ff;
   logic [WSUMW-1:0]        wsum_ff;
   logic [WTSW-1:0]         wtsum_ff;
   logic [CW-1:0]           count_ff;
   logic signed [SPRSW-1:0] spr_ff;
   logic [DSUMW-1:0]        dsum_ff;
   logic [CW-1:0]           dn_ff;
   logic [MIDW-1:0]         dmax_ff;
   logic [SW-1:0]           worst_ff;
   logic                    found_ff;
   logic [MIDW-1:0]         cmid_ff;
   logic signed [QW:0]      smean_ff;
   logic [16:0]             conf_ff;
   logic [MIDW-1:0]         dmean_ff;
   logic                    cons_ff;
   logic [MIDW-1:0]         dev_c;

   assign dev_c = (mid_ff > cmid_ff) ? (mid_ff - cmid_ff) : (cmid_ff - mid_ff);

   // Divider operands and result.
   logic             spr_neg;
   logic [SPRSW-1:0] spr_mag;
   logic [WSUMW-1:0] div_n;
   logic [WTSW-1:0]  div_d;
   logic             div_done;
   logic [QW-1:0]    div_q;
   logic [QW:0]      q_ext;

   always_comb begin
      spr_neg = spr_ff[SPRSW-1];
      spr_mag = spr_neg ? SPRSW'(-spr_ff) : SPRSW'(spr_ff);
      q_ext   = {1'b0, div_q};
      case (cmd.div_sel)
         wfct_pkg::DIV_MID: begin
            div_n = wsum_ff;
            div_d = wtsum_ff;
         end
         wfct_pkg::DIV_SPR: begin
            div_n = WSUMW'(spr_mag);
            div_d = WTSW'(count_ff);
         end
         wfct_pkg::DIV_CONF: begin
            div_n = WSUMW'(wtsum_ff);
            div_d = WTSW'(count_ff);
         end
         default: begin
            div_n = WSUMW'(dsum_ff);
            div_d = WTSW'(dn_ff);
         end
      endcase
   end

   wfct_div #(
      .NW  (WSUMW),
      .DVW (WTSW),
      .QW  (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         base_ff  <= base_full[AW-1:0];
         src_ff   <= '0;
         wsum_ff  <= '0;
         wtsum_ff <= '0;
         count_ff <= '0;
         spr_ff   <= '0;
         dsum_ff  <= '0;
         dn_ff    <= '0;
         dmax_ff  <= '0;
         worst_ff <= '0;
         found_ff <= 1'b0;
         cmid_ff  <= '0;
         smean_ff <= '0;
         conf_ff  <= '0;
         dmean_ff <= '0;
         cons_ff  <= 1'b0;
      end else begin
         if (cmd.src_clear) begin
            src_ff <= '0;
         end else if (cmd.src_next) begin
            src_ff <= SW'(src_ff + 1'b1);
         end
         if (cmd.p1_stage) begin
            mid_ff  <= mid_c;
            wt_ff   <= wt_rd_ff;
            incl_ff <= used_rd_ff && (wt_rd_ff != '0) && (mid_c != '0);
            term_ff <= term_c;
         end
         if (cmd.p2_stage) begin
            mid_ff  <= mid_c;
            incl_ff <= used_rd_ff && (mid_c != '0);
         end
         if (cmd.p1_mul) begin
            prod_ff <= PRODW'(mid_ff) * PRODW'(wt_ff);
         end
         if (cmd.p1_acc && incl_ff) begin
            wsum_ff  <= wsum_ff + WSUMW'(prod_ff);
            wtsum_ff <= wtsum_ff + WTSW'(wt_ff);
            count_ff <= CW'(count_ff + 1'b1);
            spr_ff   <= spr_ff + SPRSW'(term_ff);
         end
         if (cmd.p2_acc && incl_ff) begin
            dsum_ff <= dsum_ff + DSUMW'(dev_c);
            dn_ff   <= CW'(dn_ff + 1'b1);
            if (dev_c > dmax_ff) begin
               dmax_ff  <= dev_c;
               worst_ff <= src_ff;
               found_ff <= 1'b1;
            end
         end
         if (cmd.div_capture) begin
            case (cmd.cap_sel)
               wfct_pkg::DIV_MID: begin
                  cmid_ff <= div_q[MIDW-1:0];
                  cons_ff <= 1'b1;
               end
               wfct_pkg::DIV_SPR: begin
                  smean_ff <= spr_neg ? -$signed(q_ext) : $signed(q_ext);
               end
               wfct_pkg::DIV_CONF: begin
                  conf_ff <= (div_q > QW'(wfct_pkg::CONF_ONE)) ? wfct_pkg::CONF_ONE
                                                               : div_q[16:0];
               end
               default: begin
                  dmean_ff <= div_q[MIDW-1:0];
               end
            endcase
         end
      end
   end

   // Result registers.
   logic [63:0] cmid64, dmax64, dmean64, worst64, count64;
   logic signed [63:0] smean64;

   always_comb begin
      cmid64  = 64'(cmid_ff);
      dmax64  = 64'(dmax_ff);
      dmean64 = 64'(dmean_ff);
      worst64 = 64'(worst_ff);
      count64 = 64'(count_ff);
      smean64 = 64'(smean_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_consensus_valid    <= cons_ff;
         rsp_mid_price          <= cmid64[39:0];
         rsp_mean_spread        <= smean64[40:0];
         rsp_confidence         <= conf_ff;
         rsp_contributing_count <= count64[3:0];
         rsp_divergence_valid   <= (dn_ff != '0);
         rsp_max_divergence     <= dmax64[39:0];
         rsp_mean_divergence    <= dmean64[39:0];
         rsp_outlier_valid      <= found_ff;
         rsp_outlier_source     <= worst64[2:0];
      end
   end

   always_comb begin
      status.src_last  = (src_ff == SW'(SOURCE_COUNT - 1));
      status.wsum_zero = (wtsum_ff == '0);
      status.cmid_zero = (cmid_ff == '0);
      status.dn_zero   = (dn_ff == '0);
      status.inst_oob  = (32'(req_instrument_index) >= 32'(INSTRUMENT_COUNT));
      status.div_done  = div_done;
   end
endmodule
`default_nettype wire

// File: sv/wfct_ctrl.sv
// Controller of the weighted feed consensus table: sequences ingest writes,
// the two source walks, the divisions and the result transfer.
// Depends on wfct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wfct_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_opcode,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire wfct_pkg::status_type status,
   output wfct_pkg::cmd_type         cmd
);
   wfct_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfct_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.div_sel  = wfct_pkg::DIV_MID;
      cmd.cap_sel  = wfct_pkg::DIV_MID;
      req_ready    = (state_ff == wfct_pkg::ST_IDLE);
      case (state_ff)
         wfct_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == wfct_pkg::OP_INGEST) begin
                  cmd.write_entry = 1'b1;
               end else begin
                  cmd.load_query = 1'b1;
                  state_in = status.inst_oob ? wfct_pkg::ST_FINISH : wfct_pkg::ST_P1_RD;
               end
            end
         end
         wfct_pkg::ST_P1_RD: begin
            cmd.rd_issue = 1'b1;
            state_in = wfct_pkg::ST_P1_MID;
         end
         wfct_pkg::ST_P1_MID: begin
            cmd.p1_stage = 1'b1;
            state_in = wfct_pkg::ST_P1_MUL;
         end
         wfct_pkg::ST_P1_MUL: begin
            cmd.p1_mul = 1'b1;
            state_in = wfct_pkg::ST_P1_ACC;
         end
         wfct_pkg::ST_P1_ACC: begin
            cmd.p1_acc = 1'b1;
            if (status.src_last) begin
               state_in = wfct_pkg::ST_CHECK;
            end else begin
               cmd.src_next = 1'b1;
               state_in = wfct_pkg::ST_P1_RD;
            end
         end
         wfct_pkg::ST_CHECK: begin
            if (status.wsum_zero) begin
               state_in = wfct_pkg::ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = wfct_pkg::DIV_MID;
               state_in = wfct_pkg::ST_DIV_MID;
            end
         end
         wfct_pkg::ST_DIV_MID: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.cap_sel     = wfct_pkg::DIV_MID;
               cmd.div_start   = 1'b1;
               cmd.div_sel     = wfct_pkg::DIV_SPR;
               state_in = wfct_pkg::ST_DIV_SPR;
            end
         end
         wfct_pkg::ST_DIV_SPR: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.cap_sel     = wfct_pkg::DIV_SPR;
               cmd.div_start   = 1'b1;
               cmd.div_sel     = wfct_pkg::DIV_CONF;
               state_in = wfct_pkg::ST_DIV_CONF;
            end
         end
         wfct_pkg::ST_DIV_CONF: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.cap_sel     = wfct_pkg::DIV_CONF;
               state_in = wfct_pkg::ST_P2_CHK;
            end
         end
         wfct_pkg::ST_P2_CHK: begin
            if (status.cmid_zero) begin
               state_in = wfct_pkg::ST_FINISH;
            end else begin
               cmd.src_clear = 1'b1;
               state_in = wfct_pkg::ST_P2_RD;
            end
         end
         wfct_pkg::ST_P2_RD: begin
            cmd.rd_issue = 1'b1;
            state_in = wfct_pkg::ST_P2_MID;
         end
         wfct_pkg::ST_P2_MID: begin
            cmd.p2_stage = 1'b1;
            state_in = wfct_pkg::ST_P2_ACC;
         end
         wfct_pkg::ST_P2_ACC: begin
            cmd.p2_acc = 1'b1;
            if (status.src_last) begin
               state_in = wfct_pkg::ST_P2_END;
            end else begin
               cmd.src_next = 1'b1;
               state_in = wfct_pkg::ST_P2_RD;
            end
         end
         wfct_pkg::ST_P2_END: begin
            if (status.dn_zero) begin
               state_in = wfct_pkg::ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = wfct_pkg::DIV_DMEAN;
               state_in = wfct_pkg::ST_DIV_DMEAN;
            end
         end
         wfct_pkg::ST_DIV_DMEAN: begin
            cmd.div_sel = wfct_pkg::DIV_DMEAN;
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.cap_sel     = wfct_pkg::DIV_DMEAN;
               state_in = wfct_pkg::ST_FINISH;
            end
         end
         wfct_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = wfct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfct_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// File: sv/weighted_feed_consensus_table_core.sv
// Top level of the weighted feed consensus table: controller plus datapath.
// Depends on wfct_pkg, wfct_ctrl and wfct_datapath.
//
// Usage. The req_ channel carries one item per transfer. An ingest item
// (req_opcode 0) stores the quote of one instrument and source together
// with its weight and produces no result; the next item may follow in the
// next cycle. A query item (req_opcode 1) walks the instrument's sources
// twice and yields one transfer on the rsp_ channel. The first walk reads,
// forms the mid, multiplies and accumulates for each source; the second
// walk reads, forms the mid and accumulates for each source; the shared
// one-bit-per-cycle divider is used four times. The block is ready for the
// next item in the cycle in which the result appears on the rsp_ channel.
// Queries on an unknown instrument, or with no contributing weight, finish
// at once or after the first walk.
// The result sits in an output register: while the receiver stalls
// rsp_ready, the block keeps taking ingest items and starts the next query,
// and that query waits at its end until the register is free.
// Reset clears the used bit of every entry, so a query after reset sees an
// empty table; the quote memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module weighted_feed_consensus_table_core #(
   parameter int INSTRUMENT_COUNT = wfct_pkg::INSTRUMENT_COUNT_DEFAULT,
   parameter int SOURCE_COUNT     = wfct_pkg::SOURCE_COUNT_DEFAULT,
   parameter int PRICE_BITS       = wfct_pkg::PRICE_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [3:0]  req_instrument_index,
   input  wire logic [2:0]  req_source_index,
   input  wire logic [31:0] req_bid_price,
   input  wire logic [31:0] req_ask_price,
   input  wire logic [31:0] req_last_price,
   input  wire logic        req_bid_present,
   input  wire logic        req_ask_present,
   input  wire logic        req_last_present,
   input  wire logic [16:0] req_reliability,
   input  wire logic [16:0] req_usefulness,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_consensus_valid,
   output logic [39:0]      rsp_mid_price,
   output logic signed [40:0] rsp_mean_spread,
   output logic [16:0]      rsp_confidence,
   output logic [3:0]       rsp_contributing_count,
   output logic             rsp_divergence_valid,
   output logic [39:0]      rsp_max_divergence,
   output logic [39:0]      rsp_mean_divergence,
   output logic             rsp_outlier_valid,
   output logic [2:0]       rsp_outlier_source
);
   // Commands from the controller and status back from the datapath.
   wfct_pkg::cmd_type    cmd;
   wfct_pkg::status_type status;

   wfct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   wfct_datapath #(
      .INSTRUMENT_COUNT (INSTRUMENT_COUNT),
      .SOURCE_COUNT     (SOURCE_COUNT),
      .PRICE_BITS       (PRICE_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_instrument_index   (req_instrument_index),
      .req_source_index       (req_source_index),
      .req_bid_price          (req_bid_price),
      .req_ask_price          (req_ask_price),
      .req_last_price         (req_last_price),
      .req_bid_present        (req_bid_present),
      .req_ask_present        (req_ask_present),
      .req_last_present       (req_last_present),
      .req_reliability        (req_reliability),
      .req_usefulness         (req_usefulness),
      .rsp_consensus_valid    (rsp_consensus_valid),
      .rsp_mid_price          (rsp_mid_price),
      .rsp_mean_spread        (rsp_mean_spread),
      .rsp_confidence         (rsp_confidence),
      .rsp_contributing_count (rsp_contributing_count),
      .rsp_divergence_valid   (rsp_divergence_valid),
      .rsp_max_divergence     (rsp_max_divergence),
      .rsp_mean_divergence    (rsp_mean_divergence),
      .rsp_outlier_valid      (rsp_outlier_valid),
      .rsp_outlier_source     (rsp_outlier_source)
   );
endmodule
`default_nettype wire

// File: tb/weighted_feed_consensus_table_core_tb.sv
// Testbench of weighted_feed_consensus_table_core: a directed table and random
// ingest/query traffic, checked against a predictor of the quote table.
// Depends on wfct_pkg and weighted_feed_consensus_table_core.
`timescale 1ns / 1ps
module weighted_feed_consensus_table_core_tb;

   // One query result, field by field as the rsp_ ports carry it.
   typedef struct packed {
      logic        consensus_valid;
      logic [39:0] cons_mid;
      logic [40:0] mean_spread;
      logic [16:0] confidence;
      logic [3:0]  contributing_count;
      logic        divergence_valid;
      logic [39:0] dev_max;
      logic [39:0] dev_mean;
      logic        outlier_valid;
      logic [2:0]  outlier_source;
   } consensus_type;

   // One request, plus an optional hand-typed expectation for directed queries.
   typedef struct {
      logic          op;
      logic [3:0]    inst;
      logic [2:0]    src;
      logic [31:0]   bid;
      logic [31:0]   ask;
      logic [31:0]   last;
      logic          bid_p;
      logic          ask_p;
      logic          last_p;
      logic [16:0]   rel;
      logic [16:0]   usefulness;
      bit            typed;
      consensus_type typed_result;
   } quote_req_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_opcode;
   logic [3:0] req_instrument_index;
   logic [2:0] req_source_index;
   logic [31:0] req_bid_price;
   logic [31:0] req_ask_price;
   logic [31:0] req_last_price;
   logic req_bid_present;
   logic req_ask_present;
   logic req_last_present;
   logic [16:0] req_reliability;
   logic [16:0] req_usefulness;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_consensus_valid;
   logic [39:0] rsp_mid_price;
   logic signed [40:0] rsp_mean_spread;
   logic [16:0] rsp_confidence;
   logic [3:0] rsp_contributing_count;
   logic rsp_divergence_valid;
   logic [39:0] rsp_max_divergence;
   logic [39:0] rsp_mean_divergence;
   logic rsp_outlier_valid;
   logic [2:0] rsp_outlier_source;

   weighted_feed_consensus_table_core dut (.*);

   // Shadow copy of the quote table, indexed by instrument*8 + source.
   bit          shadow_used[128];
   logic [31:0] shadow_bid[128];
   logic [31:0] shadow_ask[128];
   logic [31:0] shadow_last[128];
   logic [2:0]  shadow_pres[128];
   logic [17:0] shadow_weight[128];

   consensus_type pending_results[$];  // expected results, oldest first
   quote_req_type override_q[$];       // one entry per query, in transfer order
   quote_req_type directed_rows[$];
   int error_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A generous bound for the whole run, even under the worst stall pattern.
   initial begin
      #40_000_000;
      $display("weighted_feed_consensus_table_core_tb: FAIL");
      $finish;
   end

   function automatic void add_row(quote_req_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic logic [63:0] quote_mid(int e);
      if (shadow_pres[e][1:0] == 2'b11)
         return ({32'd0, shadow_bid[e]} + {32'd0, shadow_ask[e]}) << 7;
      if (shadow_pres[e][2])
         return {32'd0, shadow_last[e]} << 8;
      return 64'd0;
   endfunction

   function automatic void store_quote(quote_req_type r);
      int e;
      logic [63:0] w;
      e = r.inst * 8 + r.src;
      shadow_used[e] = 1'b1;
      shadow_bid[e] = r.bid;
      shadow_ask[e] = r.ask;
      shadow_last[e] = r.last;
      shadow_pres[e] = {r.last_p, r.ask_p, r.bid_p};
      w = ({47'd0, r.rel} * ({47'd0, r.usefulness} + 64'd32768)) >> 16;
      shadow_weight[e] = (w > 64'd262143) ? wfct_pkg::WEIGHT_MAX : w[17:0];
   endfunction

   function automatic consensus_type predict_consensus(logic [3:0] inst);
      consensus_type res;
      logic [127:0] wsum;
      logic [127:0] cmid;
      logic [63:0] wt_total, n, m, d, dmax, dsum, dn, conf, dmean;
      longint spr_total, spread_mean;
      int e;
      res = '0;
      wsum = '0;
      wt_total = 0;
      n = 0;
      spr_total = 0;
      for (int s = 0; s < 8; s++) begin
         e = inst * 8 + s;
         if (!shadow_used[e] || shadow_weight[e] == 0) continue;
         m = quote_mid(e);
         if (m == 0) continue;
         wsum += {64'd0, m} * {110'd0, shadow_weight[e]};
         wt_total += 64'(shadow_weight[e]);
         if (shadow_pres[e][1:0] == 2'b11)
            spr_total += (longint'({32'd0, shadow_ask[e]})
                          - longint'({32'd0, shadow_bid[e]})) * 256;
         n++;
      end
      if (wt_total == 0) return res;
      cmid = wsum / {64'd0, wt_total};
      spread_mean = spr_total / longint'(n);
      conf = wt_total / n;
      if (conf > 64'd65536) conf = 64'd65536;
      res.consensus_valid = 1'b1;
      res.cons_mid = cmid[39:0];
      res.mean_spread = spread_mean[40:0];
      res.confidence = conf[16:0];
      res.contributing_count = n[3:0];
      if (cmid == 0) return res;
      // Divergence covers every stored source with a mid, zero weight included.
      dmax = 0;
      dsum = 0;
      dn = 0;
      for (int s = 0; s < 8; s++) begin
         e = inst * 8 + s;
         if (!shadow_used[e]) continue;
         m = quote_mid(e);
         if (m == 0) continue;
         d = (m > cmid[63:0]) ? m - cmid[63:0] : cmid[63:0] - m;
         dsum += d;
         dn++;
         if (d > dmax) begin
            dmax = d;
            res.outlier_valid = 1'b1;
            res.outlier_source = s[2:0];
         end
      end
      if (dn > 0) begin
         dmean = dsum / dn;
         res.divergence_valid = 1'b1;
         res.dev_max = dmax[39:0];
         res.dev_mean = dmean[39:0];
      end
      return res;
   endfunction

   // Request side: at each accepted transfer update the shadow table or
   // queue the expected result of the query.
   always @(posedge clock) begin
      quote_req_type r;
      if (!reset && req_valid && req_ready) begin
         if (req_opcode == wfct_pkg::OP_INGEST) begin
            r.inst = req_instrument_index;
            r.src = req_source_index;
            r.bid = req_bid_price;
            r.ask = req_ask_price;
            r.last = req_last_price;
            r.bid_p = req_bid_present;
            r.ask_p = req_ask_present;
            r.last_p = req_last_present;
            r.rel = req_reliability;
            r.usefulness = req_usefulness;
            store_quote(r);
         end else begin
            r = override_q.pop_front();
            if (r.typed)
               pending_results.insert(pending_results.size(), r.typed_result);
            else
               pending_results.insert(pending_results.size(),
                                      predict_consensus(req_instrument_index));
         end
      end
   end

   task automatic check_field(string name, logic [63:0] expv, logic [63:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expv, actv);
         error_count++;
      end
   endtask

   // Result side: compare each transfer with the oldest expectation.
   always @(posedge clock) begin
      consensus_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with no query outstanding", $time);
            error_count++;
         end else begin
            x = pending_results.pop_front();
            check_field("rsp_consensus_valid", 64'(x.consensus_valid),
                        64'(rsp_consensus_valid));
            check_field("rsp_mid_price", 64'(x.cons_mid), 64'(rsp_mid_price));
            check_field("rsp_mean_spread", 64'(x.mean_spread),
                        64'($unsigned(rsp_mean_spread)));
            check_field("rsp_confidence", 64'(x.confidence), 64'(rsp_confidence));
            check_field("rsp_contributing_count", 64'(x.contributing_count),
                        64'(rsp_contributing_count));
            check_field("rsp_divergence_valid", 64'(x.divergence_valid),
                        64'(rsp_divergence_valid));
            check_field("rsp_max_divergence", 64'(x.dev_max),
                        64'(rsp_max_divergence));
            check_field("rsp_mean_divergence", 64'(x.dev_mean),
                        64'(rsp_mean_divergence));
            check_field("rsp_outlier_valid", 64'(x.outlier_valid),
                        64'(rsp_outlier_valid));
            check_field("rsp_outlier_source", 64'(x.outlier_source),
                        64'(rsp_outlier_source));
         end
      end
   end

   // The receiver stalls at the percentage of the current idling phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic quote_req_type ingest(int inst, int src, logic [31:0] bid,
                                            logic [31:0] ask, logic [31:0] last,
                                            logic [2:0] pres, int rel, int usefulness);
      quote_req_type r;
      r = '{default: '0};
      r.op = wfct_pkg::OP_INGEST;
      r.inst = 4'(inst);
      r.src = 3'(src);
      r.bid = bid;
      r.ask = ask;
      r.last = last;
      {r.last_p, r.ask_p, r.bid_p} = pres;
      r.rel = 17'(rel);
      r.usefulness = 17'(usefulness);
      return r;
   endfunction

   function automatic quote_req_type query(int inst);
      quote_req_type r;
      r = '{default: '0};
      r.op = wfct_pkg::OP_QUERY;
      r.inst = 4'(inst);
      // Query items still carry random payload the block must ignore.
      r.src = 3'($urandom);
      r.bid = $urandom;
      r.ask = $urandom;
      r.last = $urandom;
      r.rel = 17'($urandom);
      r.usefulness = 17'($urandom);
      return r;
   endfunction

   function automatic quote_req_type typed_query(int inst, consensus_type res);
      quote_req_type r;
      r = query(inst);
      r.typed = 1'b1;
      r.typed_result = res;
      return r;
   endfunction

   // Random item: most traffic lands on a few instruments with prices close
   // together, so queries see several contributors; the rest is wide noise.
   function automatic quote_req_type random_item();
      logic [31:0] base;
      int inst;
      inst = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(15);
      if ($urandom_range(99) < 30) return query(inst);
      base = ($urandom_range(9) == 0) ? 32'hFFFF_FF00 + $urandom_range(255)
           : ($urandom_range(3) == 0) ? $urandom : $urandom_range(100000);
      return ingest(inst, $urandom_range(7),
         ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(40),
         ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(40),
         ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(40),
         ($urandom_range(99) < 60) ? 3'b111 : 3'($urandom_range(7)),
         ($urandom_range(9) == 0) ? $urandom_range(131071) : $urandom_range(65536),
         ($urandom_range(9) == 0) ? $urandom_range(131071) : $urandom_range(65536));
   endfunction

   task automatic send(quote_req_type r);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (r.op == wfct_pkg::OP_QUERY) override_q.insert(override_q.size(), r);
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_instrument_index <= r.inst;
      req_source_index <= r.src;
      req_bid_price <= r.bid;
      req_ask_price <= r.ask;
      req_last_price <= r.last;
      req_bid_present <= r.bid_p;
      req_ask_present <= r.ask_p;
      req_last_present <= r.last_p;
      req_reliability <= r.rel;
      req_usefulness <= r.usefulness;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      consensus_type res;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= wfct_pkg::OP_INGEST;
      req_instrument_index <= '0;
      req_source_index <= '0;
      req_bid_price <= '0;
      req_ask_price <= '0;
      req_last_price <= '0;
      req_bid_present <= 1'b0;
      req_ask_present <= 1'b0;
      req_last_present <= 1'b0;
      req_reliability <= '0;
      req_usefulness <= '0;
      rsp_ready <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed rows. A query on an empty table gives an all-zero result.
      add_row(typed_query(0, '0));
      // Largest bid and ask: mid is 2^40 - 256, confidence capped at one.
      add_row(ingest(1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 3'b011, 65536, 65536));
      res = '0;
      res.consensus_valid = 1'b1;
      res.cons_mid = 40'hFF_FFFF_FF00;
      res.confidence = wfct_pkg::CONF_ONE;
      res.contributing_count = 4'd1;
      res.divergence_valid = 1'b1;
      add_row(typed_query(1, res));
      // Weight saturation on out-of-range reliability and usefulness.
      add_row(ingest(2, 7, 0, 0, 32'hFFFF_FFFF, 3'b100, 131071, 131071));
      add_row(query(2));
      // Negative spread, a source with no price, and one of zero weight.
      add_row(ingest(2, 3, 1000, 900, 7, 3'b111, 65536, 0));
      add_row(ingest(2, 5, 50, 60, 70, 3'b000, 65536, 65536));
      add_row(ingest(2, 6, 0, 0, 500, 3'b100, 0, 65536));
      add_row(query(2));
      // Zero prices give a zero mid, so there is no consensus.
      add_row(ingest(3, 0, 0, 0, 0, 3'b111, 65536, 65536));
      add_row(typed_query(3, '0));
      // Bid alone falls back to last; equal divergence picks the first source.
      add_row(ingest(4, 0, 9, 0, 100, 3'b101, 40000, 20000));
      add_row(ingest(4, 1, 0, 0, 300, 3'b110, 40000, 20000));
      add_row(query(4));
      // Overwrite an entry, and zero reliability with maximum usefulness.
      add_row(ingest(1, 0, 0, 2, 1, 3'b011, 1, 1));
      add_row(ingest(1, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                     3'b111, 98765, 12345));
      add_row(ingest(1, 2, 5, 6, 8, 3'b111, 0, 131071));
      add_row(query(1));
      add_row(ingest(15, 7, 1, 1, 1, 3'b111, 65536, 65536));
      add_row(query(15));
      foreach (directed_rows[i]) send(directed_rows[i]);

      // Three idling phases; in the first one the sender holds off once
      // until every outstanding result has come back.
      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 14 : (phase == 1) ? 88 : 0;
         stall_pct = (phase == 0) ? 88 : (phase == 1) ? 14 : 0;
         for (int i = 0; i < 650; i++) begin
            if (phase == 0 && i == 325) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_results.size() != 0) @(posedge clock);
            end
            send(random_item());
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("weighted_feed_consensus_table_core_tb: PASS");
      end else begin
         $display("weighted_feed_consensus_table_core_tb: FAIL");
      end
      $finish;
   end
endmodule
